[hw/rtl/sha256_stream_hasher_assert.svh]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shared concurrent assertion forms for the hasher RTL.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Assert that a condition implies a consequence in the same cycle.
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Constants, round table, helper functions and the control state type.
// ----------------------------------------------------------------------------
package sha_pkg;
	localparam int BlockBytes = 64;
	localparam int HashWords = 8;
	localparam int Rounds = 64;
	localparam logic [7:0] PadByte = 8'h80;
	localparam int LenOffset = 56;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_WORD,
		ST_ROUND,
		ST_RDHASH,
		ST_ADD,
		ST_EMIT,
		ST_INIT
	} state_t;

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k [0:63];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		return k[idx];
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] idx);
		logic [31:0] h [0:7];
		h = '{
			32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
		};
		return h[idx];
	endfunction

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage

[hw/rtl/sha_ram.sv]
// ----------------------------------------------------------------------------
// SHA generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sha_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hw/rtl/sha_round.sv]
// ----------------------------------------------------------------------------
// SHA-256 round datapath
// Holds the working variables and the sixteen-word schedule window;
// performs one round per cycle while round_en is high.
// ----------------------------------------------------------------------------
module sha_round (
	input  logic        clk,
	input  logic        load_hash,
	input  logic [2:0]  load_idx,
	input  logic [31:0] load_val,
	input  logic        shift_w,
	input  logic [31:0] w_in,
	input  logic        round_en,
	input  logic [5:0]  round_idx,
	input  logic [2:0]  var_idx,
	output logic [31:0] var_out
);
	import sha_pkg::*;

	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] w_cur, w_next, s0, s1, t1, t2, e, a;

	always_comb begin
		s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		w_next = s1 + w_q[9] + s0 + w_q[0];
		// The first sixteen rounds use the loaded message words directly.
		w_cur = (round_idx < 6'd16) ? w_q[round_idx[3:0]] : w_next;
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(round_idx) + w_cur;
		t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (load_hash) begin
			v_q[load_idx] <= load_val;
		end else if (round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (shift_w) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_in;
		end else if (round_en && round_idx >= 6'd16) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_next;
		end
	end

	// Rounds 0..15 index the window directly; from 16 on it slides.
	assign var_out = v_q[var_idx];
endmodule

[hw/rtl/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with memory-held block buffer and hash state.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one item per transfer; kind 0 appends
// data_byte to the message, kind 1 ends the message. The output channel
// returns eight transfers per ended message: digest words 0 through 7,
// with last_word high on the eighth.
// A byte that completes a block starts a compression: the hash words are
// copied from the hash RAM into the round unit, the 64 buffer bytes are read
// one per cycle into the schedule window, 64 rounds run one per cycle, and
// the eight hash words are read, added and written back.
// An end item writes the padding bytes one per cycle (64 minus the fill, and
// 64 more plus one extra compression when the length spills into a second
// block). The last compression skips the write-back: each digest word is
// read, added and then held on the output until it is taken.
// After reset, and again after every digest, the hash RAM is loaded with the
// initial values while stall stays high. While the receiver stalls, the
// current digest word holds and the block waits; input stays stalled until
// the digest is fully sent.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_assert.svh"

module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha_pkg::*;

	state_t state_q, state_d;
	logic [5:0]  fill_q;        // bytes held in the block buffer
	logic [63:0] bits_q;        // message length in bits
	logic        ending_q;      // inside end-of-message handling
	logic        final_q;       // current compression is the last one
	logic [6:0]  cnt_q;         // general step counter
	logic [23:0] word_q;        // first three bytes of the next schedule word
	logic [2:0]  emit_q;

	// Block RAM ports.
	logic       b_we;
	logic [5:0] b_waddr, b_raddr;
	logic [7:0] b_wdata, b_rdata;
	// Hash RAM ports.
	logic        h_we;
	logic [2:0]  h_waddr, h_raddr;
	logic [31:0] h_wdata, h_rdata;
	// Round unit controls.
	logic        load_hash, shift_w, round_en;
	logic [31:0] var_out;

	logic in_xfer, out_xfer;
	assign in_xfer = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	sha_ram #(.Width(8), .Depth(BlockBytes)) u_block (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);
	sha_ram #(.Width(32), .Depth(HashWords)) u_hash (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	// Padding byte for position fill_q during the pad pass.
	logic [7:0] pad_byte;
	logic [5:0] len_sel;
	always_comb begin
		len_sel = fill_q - 6'(LenOffset);
		if (cnt_q == 7'd0) begin
			pad_byte = PadByte;
		end else if (final_q && fill_q >= 6'(LenOffset)) begin
			pad_byte = bits_q[8 * (7 - len_sel[2:0]) +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:   if (cnt_q == 7'd7) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_xfer && kind) state_d = ST_PAD;
				else if (in_xfer && fill_q == 6'd63) state_d = ST_LOAD;
			end
			ST_PAD:    if (fill_q == 6'd63) state_d = ST_LOAD;
			ST_LOAD:   if (cnt_q == 7'd8) state_d = ST_WORD;
			ST_WORD:   if (cnt_q == 7'd64) state_d = ST_ROUND;
			ST_ROUND:  if (cnt_q == 7'(Rounds - 1)) state_d = ST_RDHASH;
			ST_RDHASH: state_d = ST_ADD;
			ST_ADD: begin
				// The last compression sends each sum out before reading the next.
				if (final_q) state_d = ST_EMIT;
				else if (cnt_q == 7'd7) state_d = ending_q ? ST_PAD : ST_IDLE;
				else state_d = ST_RDHASH;
			end
			ST_EMIT: begin
				if (out_xfer && emit_q == 3'd7) state_d = ST_INIT;
				else if (out_xfer) state_d = ST_RDHASH;
			end
			default:   state_d = ST_INIT;
		endcase
	end

	// Outputs of the control.
	always_comb begin
		b_we = 1'b0;
		b_waddr = fill_q;
		b_wdata = data_byte;
		b_raddr = cnt_q[5:0];
		h_we = 1'b0;
		h_waddr = cnt_q[2:0];
		h_wdata = init_hash(cnt_q[2:0]);
		h_raddr = cnt_q[2:0];
		load_hash = 1'b0;
		shift_w = 1'b0;
		round_en = 1'b0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_INIT: h_we = 1'b1;
			ST_IDLE: begin
				in_stall = 1'b0;
				b_we = in_valid && !kind;
			end
			ST_PAD: begin
				b_we = 1'b1;
				b_wdata = pad_byte;
			end
			ST_LOAD: begin
				// Hash word cnt-1 arrives from the RAM read of last cycle.
				load_hash = cnt_q != 7'd0;
			end
			ST_WORD: shift_w = cnt_q != 7'd0 && cnt_q[1:0] == 2'd0;
			ST_ROUND: round_en = 1'b1;
			ST_RDHASH: h_raddr = cnt_q[2:0];
			ST_ADD: begin
				h_we = !final_q;
				h_waddr = cnt_q[2:0];
				h_wdata = h_rdata + var_out;
			end
			ST_EMIT: out_valid = 1'b1;
			default: in_stall = 1'b1;
		endcase
	end

	// Word index the round unit exposes; reused during add.
	logic [2:0] var_idx;
	assign var_idx = cnt_q[2:0];

	// The fourth byte of a schedule word comes straight from the read port.
	sha_round u_round (
		.clk(clk), .load_hash(load_hash), .load_idx(3'(cnt_q - 7'd1)),
		.load_val(h_rdata), .shift_w(shift_w),
		.w_in({word_q, b_rdata}), .round_en(round_en), .round_idx(cnt_q[5:0]),
		.var_idx(var_idx), .var_out(var_out)
	);

	// The digest word is the sum, held while the receiver stalls.
	logic [31:0] dig_q;
	assign digest_word = dig_q;
	assign word_index = emit_q;
	assign last_word = emit_q == 3'd7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			fill_q <= '0;
			bits_q <= '0;
			ending_q <= 1'b0;
			final_q <= 1'b0;
			cnt_q <= '0;
			emit_q <= '0;
			word_q <= '0;
			dig_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_INIT: begin
					cnt_q <= (cnt_q == 7'd7) ? 7'd0 : cnt_q + 7'd1;
					fill_q <= '0;
					bits_q <= '0;
					ending_q <= 1'b0;
					final_q <= 1'b0;
					emit_q <= '0;
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_xfer && kind) begin
						ending_q <= 1'b1;
						// The length fits behind the pad byte when it lands below 56.
						final_q <= fill_q < 6'(LenOffset);
					end else if (in_xfer) begin
						fill_q <= fill_q + 6'd1;
						bits_q <= bits_q + 64'd8;
					end
				end
				ST_PAD: begin
					cnt_q <= (fill_q == 6'd63) ? 7'd0 : 7'd1;
					fill_q <= fill_q + 6'd1;
				end
				ST_LOAD: cnt_q <= (cnt_q == 7'd8) ? 7'd0 : cnt_q + 7'd1;
				ST_WORD: begin
					// Read data arrives in the cycle after its address.
					if (cnt_q != 7'd0) word_q <= {word_q[15:0], b_rdata};
					cnt_q <= (cnt_q == 7'd64) ? 7'd0 : cnt_q + 7'd1;
				end
				ST_ROUND: begin
					cnt_q <= (cnt_q == 7'(Rounds - 1)) ? 7'd0 : cnt_q + 7'd1;
				end
				ST_RDHASH: if (final_q) emit_q <= cnt_q[2:0];
				ST_ADD: begin
					if (final_q) begin
						dig_q <= h_rdata + var_out;
					end
					if (cnt_q == 7'd7) begin
						if (!final_q && ending_q) begin
							final_q <= 1'b1;
							cnt_q <= 7'd1;
						end else begin
							cnt_q <= '0;
						end
					end else if (!final_q) begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_EMIT: begin
					if (out_xfer) begin
						emit_q <= emit_q + 3'd1;
						cnt_q <= (emit_q == 3'd7) ? 7'd0 : 7'(emit_q + 3'd1);
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	`SHA_ASSERT_IMPL(a_no_both, clk, arst_n, out_valid, in_stall, "input open during digest")
	`SHA_ASSERT_IMPL(a_last, clk, arst_n, out_valid && last_word, word_index == 3'd7, "last flag")
	`SHA_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, $stable(digest_word), "digest moved")
endmodule
